// ===== rtl/dwr_pkg.sv =====
// dwr_pkg: shared types, constants and the answer-record byte table for the
// wildcard DNS A responder. No dependencies.
`default_nettype none

package dwr_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 256;
  localparam int QUEUE_DEPTH_DEF      = 4;

  localparam int OFF_W = 9;
  localparam int PH_W  = 5;

  localparam int HDR_LEN = 12;

  localparam logic [15:0]      QTYPE_A        = 16'h0001;
  localparam logic [7:0]       FLAGS_HI       = 8'h84;
  localparam int               QR_BIT         = 7;
  localparam logic [OFF_W-1:0] ANCOUNT_HI_OFF = 9'd6;
  localparam logic [OFF_W-1:0] ANCOUNT_LO_OFF = 9'd7;
  localparam logic [OFF_W-1:0] ANS_REC_LEN    = 9'd16;

  localparam logic [31:0] ADDR_RESET = 32'hC0A8_0401;
  localparam logic [15:0] TTL_RESET  = 16'd60;

  localparam logic CFG_ANSWER_ADDRESS = 1'b0;
  localparam logic CFG_ANSWER_TTL     = 1'b1;

  typedef enum logic [1:0] {
    OUT_ANSWERED  = 2'd0,
    OUT_NO_RECORD = 2'd1,
    OUT_DROPPED   = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       final_byte;
  } in_data_t;

  typedef struct packed {
    logic             write_enable;
    logic [OFF_W-1:0] write_offset;
    logic [7:0]       write_value;
    logic             packet_complete;
    logic [1:0]       outcome;
    logic [OFF_W-1:0] response_length;
  } out_data_t;

  // one queue entry: an optional byte write and an optional closing command
  typedef struct packed {
    logic             wr_en;
    logic [OFF_W-1:0] wr_off;
    logic [7:0]       wr_val;
    logic             close;
    outcome_t         outcome;
    logic [OFF_W-1:0] base;
  } dwr_cmd_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] ttl;
  } dwr_cfg_t;

  // bytes of the 16-byte answer record, in send order
  function automatic logic [7:0] answer_byte(input logic [3:0] idx,
                                             input logic [15:0] ttl,
                                             input logic [31:0] addr);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'hC0;
      4'd1:    v = 8'h0C;
      4'd3:    v = 8'h01;
      4'd5:    v = 8'h01;
      4'd8:    v = ttl[15:8];
      4'd9:    v = ttl[7:0];
      4'd11:   v = 8'h04;
      4'd12:   v = addr[31:24];
      4'd13:   v = addr[23:16];
      4'd14:   v = addr[15:8];
      4'd15:   v = addr[7:0];
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dns_wildcard_a_responder_core.sv =====
// Wildcard DNS A responder top level: config registers, parser front end,
// command queue and response back end. Uses dwr_pkg, dwr_front, dwr_queue, dwr_back.
//
// Takes one request byte per cycle while the command queue has room. Each
// byte yields at most one response-buffer write; the last byte also yields a
// completion transaction, preceded for a request that is not dropped by the ANCOUNT
// writes and, for a type-A question, the 16 answer-record writes. The back end
// sends one result transaction per cycle while out_stall is low, so the final
// byte of a type-A request yields up to 20 result transactions; during that time
// input bytes keep flowing until the QUEUE_DEPTH-entry queue fills. Dropped requests end
// with outcome 2 and length 0; writes already sent for them are to be ignored.
`default_nettype none

module dns_wildcard_a_responder_core #(
  parameter int MAX_PACKET_BYTES = dwr_pkg::MAX_PACKET_BYTES_DEF,
  parameter int QUEUE_DEPTH      = dwr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire dwr_pkg::in_data_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output dwr_pkg::out_data_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_wdata
);
  import dwr_pkg::*;

  dwr_cfg_t cfg_r;
  dwr_cmd_t push_entry;
  dwr_cmd_t pop_entry;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.addr <= ADDR_RESET;
      cfg_r.ttl  <= TTL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ANSWER_ADDRESS: cfg_r.addr <= cfg_wdata;
        CFG_ANSWER_TTL:     cfg_r.ttl  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  dwr_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  dwr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_entry),
    .pop   (q_pop),
    .rdata (pop_entry),
    .full  (q_full),
    .empty (q_empty)
  );

  dwr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_entry   (pop_entry),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/dwr_front.sv =====
// dwr_front: per-byte request parser. Tracks header, QNAME label walk and
// question fields; pushes write/close commands into the queue. Uses dwr_pkg.
`default_nettype none

module dwr_front #(
  parameter int MAX_PACKET_BYTES = dwr_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire dwr_pkg::in_data_t in_data,
  input  wire logic             q_full,
  output logic                  q_push,
  output dwr_pkg::dwr_cmd_t     q_entry
);
  import dwr_pkg::*;

  localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int LW = $clog2(MAX_PACKET_BYTES + 256 + 1);
  localparam logic [PW-1:0] MAX_POS = PW'(MAX_PACKET_BYTES);
  localparam logic [LW-1:0] NLAB_RESET = LW'(HDR_LEN);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [LW-1:0] nlab_r, nlab_nxt;
  logic          term_r, term_nxt;
  logic [PW-1:0] nend_r, nend_nxt;
  logic [15:0]   qtype_r, qtype_nxt;
  logic          qcnz_r, qcnz_nxt;
  logic          rej_r, rej_nxt;

  logic          accept;
  logic          wr;
  logic [7:0]    val;
  logic [7:0]    b;
  logic [PW:0]   nend_ext;
  logic [PW:0]   pos_ext;
  logic          drop;
  logic [PW:0]   base_full;

  assign b        = in_data.packet_byte;
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign nend_ext = (PW+1)'(nend_r);
  assign pos_ext  = (PW+1)'(pos_r);

  always_comb begin
    pos_nxt   = pos_r;
    nlab_nxt  = nlab_r;
    term_nxt  = term_r;
    nend_nxt  = nend_r;
    qtype_nxt = qtype_r;
    qcnz_nxt  = qcnz_r;
    rej_nxt   = rej_r;
    wr        = 1'b0;
    val       = 8'h00;
    drop      = 1'b0;
    base_full = '0;
    q_entry   = '0;

    if (pos_r >= MAX_POS) begin
      rej_nxt = 1'b1;
    end else begin
      if (pos_r < PW'(HDR_LEN)) begin
        case (pos_r)
          PW'(0), PW'(1): begin
            wr  = 1'b1;
            val = b;
          end
          PW'(2): begin
            if (b[QR_BIT]) rej_nxt = 1'b1;
            wr  = 1'b1;
            val = FLAGS_HI;
          end
          PW'(4), PW'(5): begin
            if (b != 8'h00) qcnz_nxt = 1'b1;
            wr  = 1'b1;
            val = (pos_r == PW'(5)) ? 8'h01 : 8'h00;
          end
          PW'(6), PW'(7): ;
          default: begin
            wr  = 1'b1;
            val = 8'h00;
          end
        endcase
      end else if (!term_r) begin
        wr  = 1'b1;
        val = b;
        if (LW'(pos_r) == nlab_r) begin
          if (b == 8'h00) begin
            term_nxt = 1'b1;
            nend_nxt = pos_r;
          end else begin
            nlab_nxt = LW'(pos_r) + LW'(b) + LW'(1);
          end
        end
      end else if (pos_ext <= nend_ext + (PW+1)'(4)) begin
        wr  = 1'b1;
        val = b;
        if (pos_ext == nend_ext + (PW+1)'(1)) qtype_nxt[15:8] = b;
        else if (pos_ext == nend_ext + (PW+1)'(2)) qtype_nxt[7:0] = b;
      end
      pos_nxt = pos_r + PW'(1);
    end

    q_entry.wr_en  = wr && !rej_nxt;
    q_entry.wr_off = OFF_W'(pos_r);
    q_entry.wr_val = val;

    if (in_data.final_byte) begin
      base_full = (PW+1)'(nend_nxt) + (PW+1)'(5);
      drop = rej_nxt || (pos_nxt < PW'(HDR_LEN)) || !qcnz_nxt || !term_nxt ||
             (base_full > (PW+1)'(pos_nxt));
      q_entry.close   = 1'b1;
      q_entry.base    = OFF_W'(base_full);
      q_entry.outcome = drop ? OUT_DROPPED :
                        (qtype_nxt == QTYPE_A) ? OUT_ANSWERED : OUT_NO_RECORD;
      pos_nxt   = '0;
      nlab_nxt  = NLAB_RESET;
      term_nxt  = 1'b0;
      nend_nxt  = '0;
      qtype_nxt = '0;
      qcnz_nxt  = 1'b0;
      rej_nxt   = 1'b0;
    end
  end

  assign q_push = accept && (q_entry.wr_en || q_entry.close);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      nlab_r  <= NLAB_RESET;
      term_r  <= 1'b0;
      nend_r  <= '0;
      qtype_r <= '0;
      qcnz_r  <= 1'b0;
      rej_r   <= 1'b0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      nlab_r  <= nlab_nxt;
      term_r  <= term_nxt;
      nend_r  <= nend_nxt;
      qtype_r <= qtype_nxt;
      qcnz_r  <= qcnz_nxt;
      rej_r   <= rej_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dwr_queue.sv =====
// dwr_queue: small register FIFO of parser commands between front and back.
// Uses dwr_pkg.
`default_nettype none

module dwr_queue #(
  parameter int DEPTH = dwr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire dwr_pkg::dwr_cmd_t wdata,
  input  wire logic              pop,
  output dwr_pkg::dwr_cmd_t      rdata,
  output logic                   full,
  output logic                   empty
);
  import dwr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dwr_cmd_t      mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

`default_nettype wire

// ===== rtl/dwr_back.sv =====
// dwr_back: expands queued commands into response-buffer writes and a completion
// transaction, one per unstalled cycle, behind an output register. Uses dwr_pkg.
`default_nettype none

module dwr_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dwr_pkg::dwr_cfg_t cfg,
  input  wire dwr_pkg::dwr_cmd_t q_entry,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output dwr_pkg::out_data_t     out_data
);
  import dwr_pkg::*;

  localparam logic [PH_W-1:0] K_NOREC_DONE = PH_W'(2);
  localparam logic [PH_W-1:0] K_A_DONE     = PH_W'(18);

  dwr_cmd_t        cur_r, cur_nxt;
  logic            cur_vld_r, cur_vld_nxt;
  logic [PH_W-1:0] ph_r, ph_nxt;
  logic            out_vld_r, out_vld_nxt;
  out_data_t       out_r, out_nxt;

  out_data_t       res;
  logic            seq_last;
  logic [PH_W-1:0] k;
  logic [3:0]      j;
  logic            out_rdy;
  logic            advance;

  assign k = ph_r - PH_W'(1);
  assign j = 4'(k - PH_W'(2));

  always_comb begin
    res      = '0;
    seq_last = 1'b0;
    if (ph_r == '0) begin
      res.write_enable = 1'b1;
      res.write_offset = cur_r.wr_off;
      res.write_value  = cur_r.wr_val;
      seq_last         = !cur_r.close;
    end else begin
      case (cur_r.outcome)
        OUT_DROPPED: begin
          res.packet_complete = 1'b1;
          res.outcome         = OUT_DROPPED;
          seq_last            = 1'b1;
        end
        OUT_NO_RECORD: begin
          if (k == PH_W'(0)) begin
            res.write_enable = 1'b1;
            res.write_offset = ANCOUNT_HI_OFF;
          end else if (k == PH_W'(1)) begin
            res.write_enable = 1'b1;
            res.write_offset = ANCOUNT_LO_OFF;
          end else begin
            res.packet_complete = 1'b1;
            res.outcome         = OUT_NO_RECORD;
            res.response_length = cur_r.base;
          end
          seq_last = (k == K_NOREC_DONE);
        end
        default: begin
          if (k == PH_W'(0)) begin
            res.write_enable = 1'b1;
            res.write_offset = ANCOUNT_HI_OFF;
          end else if (k == PH_W'(1)) begin
            res.write_enable = 1'b1;
            res.write_offset = ANCOUNT_LO_OFF;
            res.write_value  = 8'h01;
          end else if (k < K_A_DONE) begin
            res.write_enable = 1'b1;
            res.write_offset = cur_r.base + OFF_W'(j);
            res.write_value  = answer_byte(j, cfg.ttl, cfg.addr);
          end else begin
            res.packet_complete = 1'b1;
            res.outcome         = OUT_ANSWERED;
            res.response_length = cur_r.base + ANS_REC_LEN;
          end
          seq_last = (k == K_A_DONE);
        end
      endcase
    end
  end

  assign out_rdy = !out_vld_r || !out_stall;
  assign advance = cur_vld_r && out_rdy;
  assign q_pop   = !q_empty && (!cur_vld_r || (advance && seq_last));

  always_comb begin
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    ph_nxt      = ph_r;
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
      out_nxt     = res;
      ph_nxt      = ph_r + PH_W'(1);
      if (seq_last) cur_vld_nxt = 1'b0;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
    if (q_pop) begin
      cur_nxt     = q_entry;
      cur_vld_nxt = 1'b1;
      ph_nxt      = q_entry.wr_en ? PH_W'(0) : PH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      ph_r      <= '0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      out_vld_r <= out_vld_nxt;
      ph_r      <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== rtl/dwr_checker.sv =====
// dwr_checker: port-level assertions on the responder's result channel,
// bound to dns_wildcard_a_responder_core. Uses dwr_pkg.
`default_nettype none

module dwr_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire dwr_pkg::out_data_t out_data
);
  import dwr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.write_enable && out_data.packet_complete))
    else $error("write and completion in one transaction");

  a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.write_enable |->
      out_data.outcome == OUT_ANSWERED && out_data.response_length == '0)
    else $error("write transaction carries status");

  a_drop_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.packet_complete && out_data.outcome == OUT_DROPPED |->
      out_data.response_length == '0 && out_data.write_offset == '0)
    else $error("dropped completion with nonzero length");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind dns_wildcard_a_responder_core dwr_checker u_dwr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for dns_wildcard_a_responder_core: random DNS requests,
// a reply tracker that predicts every buffer write and completion transaction.
// Depends on dwr_pkg and the RTL of the core only.
`timescale 1ns / 1ps

module testbench;
  import dwr_pkg::*;

  class reply_tracker;
    logic [31:0] answer_addr;
    logic [15:0] answer_ttl;
    logic [8:0]  byte_pos;
    logic [9:0]  next_label;
    bit          name_done;
    logic [8:0]  name_end;
    logic [15:0] qtype;
    bit          qd_nonzero;
    bit          rejected;
    out_data_t   pending_replies[$];
    int          errors;

    function new();
      answer_addr = ADDR_RESET;
      answer_ttl  = TTL_RESET;
      errors      = 0;
      clear_request();
    endfunction

    function void clear_request();
      byte_pos   = '0;
      next_label = 10'd12;
      name_done  = 1'b0;
      name_end   = '0;
      qtype      = '0;
      qd_nonzero = 1'b0;
      rejected   = 1'b0;
    endfunction

    function void set_register(logic idx, logic [31:0] value);
      if (idx == CFG_ANSWER_ADDRESS) begin
        answer_addr = value;
      end else begin
        answer_ttl = value[15:0];
      end
    endfunction

    function void push_write(int off, logic [7:0] value);
      out_data_t r;
      r = '0;
      r.write_enable = 1'b1;
      r.write_offset = off[8:0];
      r.write_value  = value;
      pending_replies.push_back(r);
    endfunction

    function void push_done(outcome_t result, int len);
      out_data_t r;
      r = '0;
      r.packet_complete = 1'b1;
      r.outcome         = result;
      r.response_length = len[8:0];
      pending_replies.push_back(r);
    endfunction

    function void note_request_byte(in_data_t d);
      int           p;
      int           nxt;
      int           len;
      int           base;
      logic [7:0]   b;
      logic [7:0]   value;
      logic [127:0] rec;
      bit           wr;
      p = byte_pos;
      b = d.packet_byte;
      if (p >= MAX_PACKET_BYTES_DEF) begin
        rejected = 1'b1;
      end else begin
        wr    = 1'b0;
        value = '0;
        if (p < HDR_LEN) begin
          case (p)
            0, 1: begin
              wr    = 1'b1;
              value = b;
            end
            2: begin
              if (b[QR_BIT]) rejected = 1'b1;
              wr    = 1'b1;
              value = FLAGS_HI;
            end
            4, 5: begin
              if (b != 8'h00) qd_nonzero = 1'b1;
              wr    = 1'b1;
              value = (p == 5) ? 8'h01 : 8'h00;
            end
            ANCOUNT_HI_OFF, ANCOUNT_LO_OFF: ;
            default: begin
              wr    = 1'b1;
              value = 8'h00;
            end
          endcase
        end else if (!name_done) begin
          wr    = 1'b1;
          value = b;
          if (p == next_label) begin
            if (b == 8'h00) begin
              name_done = 1'b1;
              name_end  = p[8:0];
            end else begin
              nxt        = p + b + 1;
              next_label = nxt[9:0];
            end
          end
        end else if (p <= name_end + 4) begin
          wr    = 1'b1;
          value = b;
          if (p == name_end + 1) begin
            qtype[15:8] = b;
          end else if (p == name_end + 2) begin
            qtype[7:0] = b;
          end
        end
        if (wr && !rejected) push_write(p, value);
        nxt      = p + 1;
        byte_pos = nxt[8:0];
      end

      if (d.final_byte) begin
        len = byte_pos;
        if (rejected || len < HDR_LEN || !qd_nonzero || !name_done || name_end + 5 > len) begin
          push_done(OUT_DROPPED, 0);
        end else begin
          base = name_end + 5;
          if (qtype == QTYPE_A) begin
            // pointer to offset 12, type A, class IN, 32-bit TTL, rdlength 4, address
            rec = {8'hC0, 8'h0C, QTYPE_A, 16'h0001, 16'h0000, answer_ttl, 16'h0004,
                   answer_addr};
            push_write(ANCOUNT_HI_OFF, 8'h00);
            push_write(ANCOUNT_LO_OFF, 8'h01);
            for (int i = 0; i < 16; i++) push_write(base + i, rec[127 - 8*i -: 8]);
            push_done(OUT_ANSWERED, base + 16);
          end else begin
            push_write(ANCOUNT_HI_OFF, 8'h00);
            push_write(ANCOUNT_LO_OFF, 8'h00);
            push_done(OUT_NO_RECORD, base);
          end
        end
        clear_request();
      end
    endfunction

    function string show(out_data_t r);
      return $sformatf("we=%0d off=%0d val=%h done=%0d outcome=%0d len=%0d",
                       r.write_enable, r.write_offset, r.write_value,
                       r.packet_complete, r.outcome, r.response_length);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_reply(out_data_t got);
      out_data_t want;
      string     diffs;
      if (pending_replies.size() == 0) begin
        report({"transaction with nothing pending: ", show(got)});
        return;
      end
      want  = pending_replies.pop_front();
      diffs = "";
      if (got.write_enable !== want.write_enable) diffs = {diffs, " write_enable"};
      if (got.write_offset !== want.write_offset) diffs = {diffs, " write_offset"};
      if (got.write_value !== want.write_value) diffs = {diffs, " write_value"};
      if (got.packet_complete !== want.packet_complete) diffs = {diffs, " packet_complete"};
      if (got.outcome !== want.outcome) diffs = {diffs, " outcome"};
      if (got.response_length !== want.response_length) diffs = {diffs, " response_length"};
      if (diffs != "") begin
        report({"bad", diffs, ": got ", show(got), " / want ", show(want)});
      end
    endtask
  endclass

  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int TAIL_CYCLES     = 40;
  localparam int BYTES_PER_PHASE = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_data_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_data_t   out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;

  int          cycle_count = 0;
  int          in_gap_pct = 0;
  int          out_stall_pct = 0;
  logic [7:0]  pkt[$];
  reply_tracker sb = new();

  dns_wildcard_a_responder_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (cfg_we) sb.set_register(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) sb.note_request_byte(in_data);
      if (out_valid && !out_stall) sb.check_reply(out_data);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver back-pressure: segments of stall / no stall, mostly short
  initial begin
    int run;
    bit hold;
    run  = 0;
    hold = 1'b0;
    forever begin
      @(negedge clk);
      if (run == 0) begin
        hold = ($urandom_range(0, 99) < out_stall_pct);
        run  = ($urandom_range(0, 11) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
      end
      out_stall = hold;
      run--;
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0:       return 10;
      1:       return 30;
      default: return 60;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] value, input bit last);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < in_gap_pct) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.packet_byte = value;
    in_data.final_byte  = last;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic wait_for_replies(input int extra);
    in_valid = 1'b0;
    while (sb.pending_replies.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [31:0] value);
    cfg_index = idx;
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // ID, flags with QR clear, nonzero QDCOUNT, random remaining counts
  task automatic start_header();
    logic [7:0] hi;
    logic [7:0] lo;
    pkt.delete();
    pkt.push_back(rnd8());
    pkt.push_back(rnd8());
    pkt.push_back(rnd8() & 8'h7F);
    pkt.push_back(rnd8());
    hi = rnd8();
    lo = rnd8();
    case ($urandom_range(0, 2))
      0: begin
        hi = 8'h00;
        lo = 8'h01;
      end
      1: begin
        lo = 8'h00;
        if (hi == 8'h00) hi = 8'h01;
      end
      default: if (hi == 8'h00 && lo == 8'h00) lo = 8'h01;
    endcase
    pkt.push_back(hi);
    pkt.push_back(lo);
    repeat (6) pkt.push_back(rnd8());
  endtask

  task automatic add_label(input int len);
    pkt.push_back(len[7:0]);
    repeat (len) pkt.push_back(rnd8());
  endtask

  task automatic build_random_query();
    logic [15:0] qt;
    start_header();
    repeat ($urandom_range(0, 3)) add_label($urandom_range(1, 7));
    pkt.push_back(8'h00);
    case ($urandom_range(0, 3))
      0, 1:    qt = QTYPE_A;
      2:       qt = 16'h0100;
      default: qt = 16'($urandom);
    endcase
    pkt.push_back(qt[15:8]);
    pkt.push_back(qt[7:0]);
    pkt.push_back(rnd8());
    pkt.push_back(rnd8());
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) pkt.push_back(rnd8());
  endtask

  // name ends at offset 251, so the answer record reaches offset 271
  task automatic build_large_query(input bit oversize);
    start_header();
    add_label(63);
    add_label(63);
    add_label(63);
    add_label(46);
    pkt.push_back(8'h00);
    pkt.push_back(QTYPE_A[15:8]);
    pkt.push_back(QTYPE_A[7:0]);
    pkt.push_back(8'h00);
    pkt.push_back(8'h01);
    if (oversize) repeat (2) pkt.push_back(rnd8());
  endtask

  task automatic build_random_packet();
    int pick;
    int cut;
    int len;
    pick = $urandom_range(0, 99);
    if (pick >= 94) begin
      pkt.delete();
      repeat ($urandom_range(1, 30)) pkt.push_back(rnd8());
    end else if (pick >= 86) begin
      // label length that runs past the end: no terminator ever seen
      start_header();
      repeat ($urandom_range(0, 2)) add_label($urandom_range(1, 5));
      len = $urandom_range(8, 255);
      pkt.push_back(len[7:0]);
      repeat ($urandom_range(0, 6)) pkt.push_back(rnd8());
    end else begin
      build_random_query();
      if (pick >= 78) begin
        cut = $urandom_range(1, pkt.size() - 1);
        while (pkt.size() > cut) void'(pkt.pop_back());
      end else if (pick >= 71) begin
        pkt[4] = 8'h00;
        pkt[5] = 8'h00;
      end else if (pick >= 64) begin
        pkt[2] = pkt[2] | 8'h80;
      end
    end
  endtask

  initial begin
    logic [135:0] shortest_a;
    int           sent;
    shortest_a = 136'hFFFF_0100_0001_0000_0000_0000_00_0001_0001;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed: one-byte request, minimal type A request on the root name, short header
    in_gap_pct    = 30;
    out_stall_pct = 30;
    pkt.delete();
    pkt.push_back(8'hFF);
    send_packet();
    pkt.delete();
    for (int i = 0; i < 17; i++) pkt.push_back(shortest_a[135 - 8*i -: 8]);
    send_packet();
    pkt.delete();
    repeat (5) pkt.push_back(8'h00);
    send_packet();

    for (int phase = 1; phase <= 5; phase++) begin
      wait_for_replies(SETTLE_CYCLES);
      case (phase)
        1: begin
          write_register(CFG_ANSWER_ADDRESS, 32'h0000_0000);
          write_register(CFG_ANSWER_TTL, 32'hFFFF_0000);
        end
        2: begin
          write_register(CFG_ANSWER_ADDRESS, 32'hFFFF_FFFF);
          write_register(CFG_ANSWER_TTL, 32'h0000_FFFF);
        end
        default: begin
          write_register(CFG_ANSWER_ADDRESS, $urandom);
          write_register(CFG_ANSWER_TTL, $urandom);
        end
      endcase
      in_gap_pct    = (phase == 1) ? 0 : pick_pct();
      out_stall_pct = (phase == 1) ? 0 : pick_pct();
      if (phase == 2) begin
        // either the largest answer or a request two bytes past the limit
        build_large_query(1'($urandom_range(0, 1)));
        send_packet();
      end
      sent = 0;
      while (sent < BYTES_PER_PHASE) begin
        build_random_packet();
        send_packet();
        sent += pkt.size();
        if ($urandom_range(0, 7) == 0) wait_for_replies(0);
      end
    end

    out_stall_pct = 0;
    wait_for_replies(TAIL_CYCLES);
    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/dwr_pkg.sv
rtl/dwr_front.sv
rtl/dwr_queue.sv
rtl/dwr_back.sv
rtl/dns_wildcard_a_responder_core.sv
rtl/dwr_checker.sv
tb/testbench.sv
